// ----- rtl/dfmcp_pkg.sv -----
// -----------------------------------------------------------------------------
// dfmcp_pkg
// Shared constants, types and character tables for the framed command parser.
// -----------------------------------------------------------------------------
package dfmcp_pkg;

   localparam int FRAME_LIMIT = 34;
   localparam int IDX_W       = $clog2(FRAME_LIMIT + 1);
   localparam int ADDR_W      = $clog2(FRAME_LIMIT);

   localparam logic [7:0] DELIM_CHAR = 8'd36;
   localparam logic [7:0] PLUS_CHAR  = 8'd43;
   localparam logic [7:0] MINUS_CHAR = 8'd45;
   localparam logic [7:0] SPACE_CHAR = 8'd32;
   localparam logic [7:0] ZERO_CHAR  = 8'd48;
   localparam logic [7:0] NINE_CHAR  = 8'd57;
   localparam logic [7:0] TAB_CHAR   = 8'd9;
   localparam logic [7:0] CR_CHAR    = 8'd13;

   localparam logic [6:0] DUTY_MAX  = 7'd99;
   localparam logic [6:0] DUTY_OVER = 7'd100;

   localparam logic [1:0] ANN_NONE   = 2'd0;
   localparam logic [1:0] ANN_AUTO   = 2'd1;
   localparam logic [1:0] ANN_MANUAL = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_RESP
   } state_type;

   typedef enum logic [1:0] {
      PH_SKIP,
      PH_DIGITS,
      PH_DONE
   } phase_type;

   typedef struct packed {
      logic clear;
      logic step;
   } scan_ctl_type;

   typedef struct packed {
      logic       auto_ok;
      logic       manual_ok;
      logic       pwm_ok;
      logic       neg;
      logic [6:0] value;
   } scan_status_type;

   function automatic logic [7:0] auto_char(input logic [1:0] k);
      logic [7:0] c;
      case (k)
         2'd0:    c = 8'h61;  // a
         2'd1:    c = 8'h75;  // u
         2'd2:    c = 8'h74;  // t
         default: c = 8'h6f;  // o
      endcase
      return c;
   endfunction

   function automatic logic [7:0] manual_char(input logic [2:0] k);
      logic [7:0] c;
      case (k)
         3'd0:    c = 8'h6d;  // m
         3'd1:    c = 8'h61;  // a
         3'd2:    c = 8'h6e;  // n
         3'd3:    c = 8'h75;  // u
         3'd4:    c = 8'h61;  // a
         default: c = 8'h6c;  // l
      endcase
      return c;
   endfunction

   function automatic logic [7:0] pwm_char(input logic [1:0] k);
      logic [7:0] c;
      case (k)
         2'd0:    c = 8'h50;  // P
         2'd1:    c = 8'h57;  // W
         default: c = 8'h4d;  // M
      endcase
      return c;
   endfunction

endpackage

// ----- rtl/dfmcp_if.sv -----
// -----------------------------------------------------------------------------
// dfmcp_if
// Valid/ready channels for received bytes and parser results.
// -----------------------------------------------------------------------------
interface dfmcp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface dfmcp_rsp_if;
   logic       valid;
   logic       ready;
   logic       auto_mode;
   logic       manual_selected;
   logic [6:0] duty_value;
   logic [1:0] announce;

   modport source (output valid, output auto_mode, output manual_selected,
                   output duty_value, output announce, input ready);
   modport sink (input valid, input auto_mode, input manual_selected,
                 input duty_value, input announce, output ready);
endinterface

// ----- rtl/dfmcp_frame_store.sv -----
// -----------------------------------------------------------------------------
// dfmcp_frame_store
// Frame text memory, one write port and one registered read port.
// -----------------------------------------------------------------------------
module dfmcp_frame_store (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [dfmcp_pkg::ADDR_W-1:0]   wr_addr,
   input  logic [7:0]                     wr_data,
   input  logic [dfmcp_pkg::ADDR_W-1:0]   rd_addr,
   output logic [7:0]                     rd_data
);

   logic [7:0] mem [dfmcp_pkg::FRAME_LIMIT];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/dfmcp_scan_unit.sv -----
// -----------------------------------------------------------------------------
// dfmcp_scan_unit
// Per-character compare and decimal accumulate unit, stepped once per byte.
// -----------------------------------------------------------------------------
module dfmcp_scan_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  dfmcp_pkg::scan_ctl_type       ctl,
   input  logic [7:0]                    char_in,
   input  logic [dfmcp_pkg::IDX_W-1:0]   pos,
   output dfmcp_pkg::scan_status_type    status
);

   logic                 auto_ok_ff, auto_ok_in;
   logic                 manual_ok_ff, manual_ok_in;
   logic                 pwm_ok_ff, pwm_ok_in;
   logic                 neg_ff, neg_in;
   logic [6:0]           value_ff, value_in;
   dfmcp_pkg::phase_type phase_ff, phase_in;

   logic       is_blank;
   logic       is_digit;
   logic       is_sign;
   logic [3:0] digit;
   logic [9:0] acc;
   logic [6:0] acc_sat;

   assign is_blank = (char_in == dfmcp_pkg::SPACE_CHAR) ||
                     ((char_in >= dfmcp_pkg::TAB_CHAR) && (char_in <= dfmcp_pkg::CR_CHAR));
   assign is_digit = (char_in >= dfmcp_pkg::ZERO_CHAR) && (char_in <= dfmcp_pkg::NINE_CHAR);
   assign is_sign  = (char_in == dfmcp_pkg::PLUS_CHAR) || (char_in == dfmcp_pkg::MINUS_CHAR);
   assign digit    = 4'(char_in - dfmcp_pkg::ZERO_CHAR);

   // value * 10 + digit, saturating to one past the maximum
   assign acc     = {value_ff, 3'b000} + {2'b00, value_ff, 1'b0} + {6'd0, digit};
   assign acc_sat = (acc > {3'd0, dfmcp_pkg::DUTY_MAX}) ? dfmcp_pkg::DUTY_OVER : acc[6:0];

   always_comb begin
      auto_ok_in   = auto_ok_ff;
      manual_ok_in = manual_ok_ff;
      pwm_ok_in    = pwm_ok_ff;
      neg_in       = neg_ff;
      value_in     = value_ff;
      phase_in     = phase_ff;
      if (ctl.clear) begin
         auto_ok_in   = 1'b1;
         manual_ok_in = 1'b1;
         pwm_ok_in    = 1'b1;
         neg_in       = 1'b0;
         value_in     = 7'd0;
         phase_in     = dfmcp_pkg::PH_SKIP;
      end else if (ctl.step) begin
         if ((pos < 6'd4) && (char_in != dfmcp_pkg::auto_char(pos[1:0]))) begin
            auto_ok_in = 1'b0;
         end
         if ((pos < 6'd6) && (char_in != dfmcp_pkg::manual_char(pos[2:0]))) begin
            manual_ok_in = 1'b0;
         end
         if ((pos < 6'd3) && (char_in != dfmcp_pkg::pwm_char(pos[1:0]))) begin
            pwm_ok_in = 1'b0;
         end
         // number parse starts after the three-letter prefix
         if (pos >= 6'd3) begin
            case (phase_ff)
               dfmcp_pkg::PH_SKIP: begin
                  if (is_blank) begin
                     phase_in = dfmcp_pkg::PH_SKIP;
                  end else if (is_sign) begin
                     neg_in   = (char_in == dfmcp_pkg::MINUS_CHAR);
                     phase_in = dfmcp_pkg::PH_DIGITS;
                  end else if (is_digit) begin
                     value_in = acc_sat;
                     phase_in = dfmcp_pkg::PH_DIGITS;
                  end else begin
                     phase_in = dfmcp_pkg::PH_DONE;
                  end
               end
               dfmcp_pkg::PH_DIGITS: begin
                  if (is_digit) begin
                     value_in = acc_sat;
                  end else begin
                     phase_in = dfmcp_pkg::PH_DONE;
                  end
               end
               default: begin
                  phase_in = dfmcp_pkg::PH_DONE;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         auto_ok_ff   <= 1'b1;
         manual_ok_ff <= 1'b1;
         pwm_ok_ff    <= 1'b1;
         neg_ff       <= 1'b0;
         value_ff     <= 7'd0;
         phase_ff     <= dfmcp_pkg::PH_SKIP;
      end else begin
         auto_ok_ff   <= auto_ok_in;
         manual_ok_ff <= manual_ok_in;
         pwm_ok_ff    <= pwm_ok_in;
         neg_ff       <= neg_in;
         value_ff     <= value_in;
         phase_ff     <= phase_in;
      end
   end

   assign status.auto_ok   = auto_ok_ff;
   assign status.manual_ok = manual_ok_ff;
   assign status.pwm_ok    = pwm_ok_ff;
   assign status.neg       = neg_ff;
   assign status.value     = value_ff;

endmodule

// ----- rtl/dollar_framed_mode_command_parser.sv -----
// -----------------------------------------------------------------------------
// dollar_framed_mode_command_parser
// Dollar-framed mode command parser with a sequential text scan.
// -----------------------------------------------------------------------------
// Usage:
//   req_bus carries one received byte per transfer (valid/ready). Every byte
//   gives exactly one result on rsp_bus: current auto mode, manual selection,
//   duty value and an announce code for the frame closed by that byte.
//   A '$' opens a frame; the next '$' closes it, runs the command and opens a
//   new frame. Text is held in a 34-byte memory with one registered read port.
// Response:
//   a byte that does not close a frame: result valid in the cycle after its
//   transfer. A closing '$': the scan unit first walks the stored text
//   (0..33 bytes), reading one stored byte per cycle, then the result is valid.
// Throughput:
//   one byte at a time; req_bus.ready is high only while no byte is in work.
// Reset:
//   no frame open, auto mode on, manual off, duty 0; no clearing pass.
// Stall:
//   a result is held in its register until rsp_bus.ready; no byte is taken
//   meanwhile.
// -----------------------------------------------------------------------------
module dollar_framed_mode_command_parser (
   input logic        clock,
   input logic        reset,
   dfmcp_req_if.sink  req_bus,
   dfmcp_rsp_if.source rsp_bus
);

   dfmcp_pkg::state_type state_ff, state_in;

   logic [dfmcp_pkg::IDX_W-1:0]  fill_ff, fill_in;
   logic [dfmcp_pkg::IDX_W-1:0]  pos_ff, pos_in;
   logic                         in_frame_ff, in_frame_in;
   logic                         auto_ff, auto_in;
   logic                         manual_ff, manual_in;
   logic [6:0]                   duty_ff, duty_in;
   logic [1:0]                   ann_ff, ann_in;

   logic                         req_xfer;
   logic                         rsp_xfer;
   logic                         is_delim;
   logic                         overflow;
   logic                         start_walk;
   logic                         walk_done;
   logic                         wr_en;
   logic [dfmcp_pkg::ADDR_W-1:0] rd_addr;
   logic [7:0]                   rd_data;
   logic [dfmcp_pkg::IDX_W-1:0]  pos_next;

   dfmcp_pkg::scan_ctl_type      scan_ctl;
   dfmcp_pkg::scan_status_type   scan_status;

   assign req_xfer   = req_bus.valid && req_bus.ready;
   assign rsp_xfer   = rsp_bus.valid && rsp_bus.ready;
   assign is_delim   = (req_bus.rx_byte == dfmcp_pkg::DELIM_CHAR);
   assign overflow   = in_frame_ff && (fill_ff == dfmcp_pkg::IDX_W'(dfmcp_pkg::FRAME_LIMIT));
   assign start_walk = req_xfer && !overflow && in_frame_ff && is_delim;
   assign walk_done  = (pos_ff == fill_ff) || (rd_data == 8'd0);
   assign wr_en      = req_xfer && !overflow && in_frame_ff && !is_delim;
   assign pos_next   = pos_ff + 6'd1;

   // read is one ahead of the scan position; the idle read primes byte zero
   always_comb begin
      if (state_ff == dfmcp_pkg::ST_IDLE) begin
         rd_addr = '0;
      end else if (pos_next >= dfmcp_pkg::IDX_W'(dfmcp_pkg::FRAME_LIMIT)) begin
         rd_addr = pos_ff[dfmcp_pkg::ADDR_W-1:0];
      end else begin
         rd_addr = pos_next[dfmcp_pkg::ADDR_W-1:0];
      end
   end

   dfmcp_frame_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (fill_ff[dfmcp_pkg::ADDR_W-1:0]),
      .wr_data (req_bus.rx_byte),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign scan_ctl.clear = req_xfer;
   assign scan_ctl.step  = (state_ff == dfmcp_pkg::ST_WALK) && !walk_done;

   dfmcp_scan_unit u_scan (
      .clock   (clock),
      .reset   (reset),
      .ctl     (scan_ctl),
      .char_in (rd_data),
      .pos     (pos_ff),
      .status  (scan_status)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dfmcp_pkg::ST_IDLE: begin
            if (start_walk) begin
               state_in = dfmcp_pkg::ST_WALK;
            end else if (req_xfer) begin
               state_in = dfmcp_pkg::ST_RESP;
            end
         end
         dfmcp_pkg::ST_WALK: begin
            if (walk_done) begin
               state_in = dfmcp_pkg::ST_RESP;
            end
         end
         dfmcp_pkg::ST_RESP: begin
            if (rsp_xfer) begin
               state_in = dfmcp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dfmcp_pkg::ST_IDLE;
         end
      endcase
   end

   // handshake outputs
   always_comb begin
      req_bus.ready = 1'b0;
      rsp_bus.valid = 1'b0;
      unique case (state_ff)
         dfmcp_pkg::ST_IDLE: req_bus.ready = 1'b1;
         dfmcp_pkg::ST_RESP: rsp_bus.valid = 1'b1;
         default: begin
            req_bus.ready = 1'b0;
            rsp_bus.valid = 1'b0;
         end
      endcase
   end

   // datapath
   always_comb begin
      fill_in     = fill_ff;
      pos_in      = pos_ff;
      in_frame_in = in_frame_ff;
      auto_in     = auto_ff;
      manual_in   = manual_ff;
      duty_in     = duty_ff;
      ann_in      = ann_ff;
      if (req_xfer) begin
         ann_in = dfmcp_pkg::ANN_NONE;
         pos_in = '0;
         if (overflow) begin
            fill_in     = '0;
            in_frame_in = is_delim;
         end else if (in_frame_ff) begin
            if (!is_delim) begin
               fill_in = fill_ff + 6'd1;
            end
         end else begin
            in_frame_in = is_delim;
         end
      end else if ((state_ff == dfmcp_pkg::ST_WALK) && walk_done) begin
         // frame closed: act on the text, then a fresh frame is open
         if (scan_status.auto_ok && (pos_ff == 6'd4)) begin
            auto_in   = 1'b1;
            manual_in = 1'b0;
            ann_in    = dfmcp_pkg::ANN_AUTO;
         end else if (scan_status.manual_ok && (pos_ff == 6'd6)) begin
            manual_in = 1'b1;
            ann_in    = dfmcp_pkg::ANN_MANUAL;
         end else if (manual_ff && scan_status.pwm_ok && (pos_ff >= 6'd3)) begin
            auto_in = 1'b0;
            if (scan_status.neg) begin
               duty_in = 7'd0;
            end else if (scan_status.value > dfmcp_pkg::DUTY_MAX) begin
               duty_in = dfmcp_pkg::DUTY_MAX;
            end else begin
               duty_in = scan_status.value;
            end
         end
         fill_in     = '0;
         in_frame_in = 1'b1;
      end else if ((state_ff == dfmcp_pkg::ST_WALK) && !walk_done) begin
         pos_in = pos_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= dfmcp_pkg::ST_IDLE;
         fill_ff     <= '0;
         pos_ff      <= '0;
         in_frame_ff <= 1'b0;
         auto_ff     <= 1'b1;
         manual_ff   <= 1'b0;
         duty_ff     <= 7'd0;
         ann_ff      <= dfmcp_pkg::ANN_NONE;
      end else begin
         state_ff    <= state_in;
         fill_ff     <= fill_in;
         pos_ff      <= pos_in;
         in_frame_ff <= in_frame_in;
         auto_ff     <= auto_in;
         manual_ff   <= manual_in;
         duty_ff     <= duty_in;
         ann_ff      <= ann_in;
      end
   end

   assign rsp_bus.auto_mode       = auto_ff;
   assign rsp_bus.manual_selected = manual_ff;
   assign rsp_bus.duty_value      = duty_ff;
   assign rsp_bus.announce        = ann_ff;

endmodule
